// ----- hdl/lsbp_pkg.sv -----
package lsbp_pkg;

    // Default and largest supported slot count.
    localparam int SLOTS_DEF = 8;
    localparam int SLOTS_MAX = 64;

    // Widths of the fields and of the internal slot number.
    localparam int SLOT_W   = 6;
    localparam int FIELD_W  = 3;
    localparam int TAG_W    = 32;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 4;
    localparam int COUNT_W  = 4;

    // Transaction kinds.
    localparam logic [KIND_W-1:0] KIND_FILL    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TAKE    = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PARTS_TIE_BREAK = 2'd1;

    // Configuration reset values.
    localparam logic [COUNT_W-1:0] SLOTS_IN_USE_RST = 4'd8;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] slot_index;
        logic [TAG_W-1:0]   seq_tag;
        logic [TAG_W-1:0]   parts_tag;
    } in_item_t;

    typedef struct packed {
        logic               found;
        logic [FIELD_W-1:0] chosen_slot;
        logic [TAG_W-1:0]   chosen_seq;
        logic [TAG_W-1:0]   chosen_parts;
    } out_item_t;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic              fill;
        logic              rel;
        logic              claim;
        logic [SLOT_W-1:0] slot;
        logic [TAG_W-1:0]  seq;
        logic [TAG_W-1:0]  parts;
    } cell_cmd_t;

    // Running best candidate handed from cell to cell during a take.
    typedef struct packed {
        logic              valid;
        logic              have;
        logic [SLOT_W-1:0] slot;
        logic [TAG_W-1:0]  seq;
        logic [TAG_W-1:0]  parts;
    } token_t;

endpackage

// ----- hdl/lsbp_cell.sv -----
module lsbp_cell
    import lsbp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SLOT_W-1:0] my_index,
    input  logic [SLOT_W:0]   active_count,
    input  logic              tie_break,
    input  cell_cmd_t         cmd,
    input  token_t            token_in,
    output token_t            token_out
);

    logic             full_reg;
    logic             busy_reg;
    logic [TAG_W-1:0] seq_reg;
    logic [TAG_W-1:0] parts_reg;
    token_t           token_reg;

    logic   hit;
    logic   eligible;
    logic   better;
    token_t token_next;

    assign hit      = (cmd.slot == my_index);
    assign eligible = full_reg && !busy_reg && ({1'b0, my_index} < active_count);

    // This slot beats the running best on a lower sequence, or on a lower parts
    // tag at an equal sequence when tie breaking is on.
    always_comb
    begin
        better = 1'b0;
        if (eligible)
        begin
            if (!token_in.have)
            begin
                better = 1'b1;
            end
            else if (seq_reg < token_in.seq)
            begin
                better = 1'b1;
            end
            else if (tie_break && (seq_reg == token_in.seq) && (parts_reg < token_in.parts))
            begin
                better = 1'b1;
            end
        end
    end

    always_comb
    begin
        token_next = token_in;
        if (better)
        begin
            token_next.have  = 1'b1;
            token_next.slot  = my_index;
            token_next.seq   = seq_reg;
            token_next.parts = parts_reg;
        end
    end

    // Slot marks.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            busy_reg <= 1'b0;
        end
        else if (hit)
        begin
            if (cmd.fill)
            begin
                full_reg <= 1'b1;
            end
            else if (cmd.rel)
            begin
                full_reg <= 1'b0;
                busy_reg <= 1'b0;
            end
            else if (cmd.claim)
            begin
                busy_reg <= 1'b1;
            end
        end
    end

    // Slot tags.
    always_ff @(posedge clk)
    begin
        if (hit && cmd.fill)
        begin
            seq_reg   <= cmd.seq;
            parts_reg <= cmd.parts;
        end
    end

    // Candidate stage toward the next cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_reg <= '0;
        end
        else
        begin
            token_reg.valid <= token_in.valid;
            if (token_in.valid)
            begin
                token_reg.have  <= token_next.have;
                token_reg.slot  <= token_next.slot;
                token_reg.seq   <= token_next.seq;
                token_reg.parts <= token_next.parts;
            end
        end
    end

    assign token_out = token_reg;

endmodule

// ----- hdl/lowest_sequence_buffer_pick.sv -----
// Fill and release transactions are accepted back to back.
// A take walks a candidate through a chain of SLOTS cells, one cell per cycle; its
// result then passes through a pending register into the output register, and no
// transaction is accepted while the candidate is in the chain or the result is pending.
// Reset (rst_n, asynchronous, active low) clears all full and in-use marks and sets
// slots_in_use to 8 and parts_tie_break to 1; slot tags are undefined until filled.
module lowest_sequence_buffer_pick
    import lsbp_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    logic [COUNT_W-1:0] slots_in_use_reg;
    logic               tie_break_reg;
    logic               scan_reg;
    logic               pend_valid_reg;
    out_item_t          pend_reg;
    logic               out_valid_reg;
    out_item_t          out_data_reg;

    logic [SLOT_W:0] active_count;
    logic            in_fire;
    logic            in_slot_ok;
    logic            scan_exit;
    logic            out_free;
    cell_cmd_t       cmd;
    token_t          token_head;
    token_t          chain [SLOTS];

    assign cfg_ready = 1'b1;
    assign in_ready  = !scan_reg && !pend_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign scan_exit = chain[SLOTS-1].valid;

    // Active slot count, saturated to the table size.
    always_comb
    begin
        if (32'(slots_in_use_reg) > SLOTS)
        begin
            active_count = (SLOT_W+1)'(SLOTS);
        end
        else
        begin
            active_count = (SLOT_W+1)'(slots_in_use_reg);
        end
    end

    assign in_slot_ok = ((SLOT_W+1)'(in_data.slot_index) < active_count);

    // Broadcast command: a claim at the end of a scan, otherwise the accepted transaction.
    always_comb
    begin
        cmd.fill  = 1'b0;
        cmd.rel   = 1'b0;
        cmd.claim = 1'b0;
        cmd.slot  = SLOT_W'(in_data.slot_index);
        cmd.seq   = in_data.seq_tag;
        cmd.parts = in_data.parts_tag;
        if (scan_exit)
        begin
            cmd.claim = chain[SLOTS-1].have;
            cmd.slot  = chain[SLOTS-1].slot;
        end
        else if (in_fire && in_slot_ok)
        begin
            cmd.fill = (in_data.kind == KIND_FILL);
            cmd.rel  = (in_data.kind == KIND_RELEASE);
        end
    end

    // Candidate entering the first cell.
    always_comb
    begin
        token_head.valid = in_fire && (in_data.kind == KIND_TAKE);
        token_head.have  = 1'b0;
        token_head.slot  = '0;
        token_head.seq   = '0;
        token_head.parts = '0;
    end

    // Chain of slot cells.
    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        token_t link_in;

        if (i == 0)
        begin : g_head
            assign link_in = token_head;
        end
        else
        begin : g_body
            assign link_in = chain[i-1];
        end

        lsbp_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .my_index     (SLOT_W'(i)),
            .active_count (active_count),
            .tie_break    (tie_break_reg),
            .cmd          (cmd),
            .token_in     (link_in),
            .token_out    (chain[i])
        );
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_in_use_reg <= SLOTS_IN_USE_RST;
            tie_break_reg    <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SLOTS_IN_USE:    slots_in_use_reg <= cfg_data;
                CFG_PARTS_TIE_BREAK: tie_break_reg    <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // Scan control, pending result and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (token_head.valid)
            begin
                scan_reg <= 1'b1;
            end
            else if (scan_exit)
            begin
                scan_reg <= 1'b0;
            end

            if (scan_exit)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (pend_valid_reg && out_free)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (pend_valid_reg && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_exit)
        begin
            pend_reg.found <= chain[SLOTS-1].have;
            if (chain[SLOTS-1].have)
            begin
                pend_reg.chosen_slot  <= chain[SLOTS-1].slot[FIELD_W-1:0];
                pend_reg.chosen_seq   <= chain[SLOTS-1].seq;
                pend_reg.chosen_parts <= chain[SLOTS-1].parts;
            end
            else
            begin
                pend_reg.chosen_slot  <= '0;
                pend_reg.chosen_seq   <= '0;
                pend_reg.chosen_parts <= '0;
            end
        end
        if (pend_valid_reg && out_free)
        begin
            out_data_reg <= pend_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- bench/lowest_sequence_buffer_pick_tb.sv -----
module lowest_sequence_buffer_pick_tb
    import lsbp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Kind and register indexes that the package does not name.
    localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam int  SETTLE_CYCLES = 2 * SLOTS_DEF + 4;
    localparam int  PHASE_ITEMS   = 125;
    localparam int  NUM_PHASES    = 9;
    localparam int  MAX_REPORTS   = 200;
    localparam real RUN_LIMIT_NS  = 4.0e6;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    in_item_t             in_data;
    logic                 out_valid;
    logic                 out_ready;
    out_item_t            out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    // Shadow copy of the slot table and of the registers.
    bit                 full_flag [SLOTS_DEF];
    bit                 busy_flag [SLOTS_DEF];
    logic [TAG_W-1:0]   tag_seq   [SLOTS_DEF];
    logic [TAG_W-1:0]   tag_parts [SLOTS_DEF];
    logic [COUNT_W-1:0] cur_count;
    bit                 cur_tie;

    // Picks that the block still owes, oldest first.
    out_item_t pending_picks[$];
    int        mismatch_count = 0;

    // One row of the directed stimulus table.
    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t want;
    } dir_row_t;

    dir_row_t dir_tab[$];

    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;

    lowest_sequence_buffer_pick dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Apply one transaction to the shadow table and work out the pick it causes, if any.
    task automatic apply_to_table(input in_item_t it, output bit has_pick,
                                  output out_item_t pick);
        int active;
        int best;
        bit have;
        active   = (cur_count > SLOTS_DEF) ? SLOTS_DEF : int'(cur_count);
        has_pick = 1'b0;
        pick     = '0;
        have     = 1'b0;
        best     = 0;
        case (it.kind)
            KIND_FILL:
            begin
                if (int'(it.slot_index) < active)
                begin
                    full_flag[it.slot_index] = 1'b1;
                    tag_seq[it.slot_index]   = it.seq_tag;
                    tag_parts[it.slot_index] = it.parts_tag;
                end
            end
            KIND_RELEASE:
            begin
                if (int'(it.slot_index) < active)
                begin
                    full_flag[it.slot_index] = 1'b0;
                    busy_flag[it.slot_index] = 1'b0;
                end
            end
            KIND_TAKE:
            begin
                has_pick = 1'b1;
                for (int i = 0; i < active; i++)
                begin
                    if (full_flag[i] && !busy_flag[i])
                    begin
                        if (!have)
                        begin
                            have = 1'b1;
                            best = i;
                        end
                        else if (tag_seq[i] < tag_seq[best])
                            best = i;
                        else if (cur_tie && tag_seq[i] == tag_seq[best] &&
                                 tag_parts[i] < tag_parts[best])
                            best = i;
                    end
                end
                if (have)
                begin
                    busy_flag[best]   = 1'b1;
                    pick.found        = 1'b1;
                    pick.chosen_slot  = best[FIELD_W-1:0];
                    pick.chosen_seq   = tag_seq[best];
                    pick.chosen_parts = tag_parts[best];
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic add_row(input logic [KIND_W-1:0] kind, input int slot,
                           input logic [TAG_W-1:0] seq, input logic [TAG_W-1:0] parts,
                           input bit typed, input bit found, input int cslot,
                           input logic [TAG_W-1:0] cseq, input logic [TAG_W-1:0] cparts);
        dir_row_t row;
        row.item.kind         = kind;
        row.item.slot_index   = slot[FIELD_W-1:0];
        row.item.seq_tag      = seq;
        row.item.parts_tag    = parts;
        row.typed             = typed;
        row.want.found        = found;
        row.want.chosen_slot  = cslot[FIELD_W-1:0];
        row.want.chosen_seq   = cseq;
        row.want.chosen_parts = cparts;
        dir_tab.push_back(row);
    endtask

    // Offer one transaction after a random gap; called and returns at a falling edge.
    task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
        int        gap;
        bit        has_pick;
        out_item_t pick;
        if ($urandom_range(0, 39) == 0)
            send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  <= it;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        apply_to_table(it, has_pick, pick);
        if (has_pick)
            pending_picks.push_back(typed ? want : pick);
        @(negedge clk);
    endtask

    // Register write; the block is idle whenever this is called.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_SLOTS_IN_USE)
            cur_count = val;
        else if (idx == CFG_PARTS_TIE_BREAK)
            cur_tie = val[0];
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Hold off until every pick has come back, then let any fill or release finish.
    task automatic drain_and_settle();
        while (pending_picks.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Tags crowd into a few values so that equal sequences occur often.
    function automatic logic [TAG_W-1:0] random_tag();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return TAG_W'($urandom_range(0, 3));
        else if (r < 55)
            return '0;
        else if (r < 65)
            return '1;
        else
            return $urandom;
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        int       r;
        r             = $urandom_range(0, 99);
        it.kind       = (r < 40) ? KIND_FILL : (r < 60) ? KIND_RELEASE :
                        (r < 95) ? KIND_TAKE : KIND_UNUSED;
        it.slot_index = FIELD_W'($urandom_range(0, 7));
        it.seq_tag    = random_tag();
        it.parts_tag  = random_tag();
        return it;
    endfunction

    // Compare every accepted result with the oldest pick still owed.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_picks.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result found=%0d slot=%0d seq=%h parts=%h",
                             $time, out_data.found, out_data.chosen_slot,
                             out_data.chosen_seq, out_data.chosen_parts);
            end
            else
            begin
                want = pending_picks.pop_front();
                if (out_data.found !== want.found ||
                    out_data.chosen_slot !== want.chosen_slot ||
                    out_data.chosen_seq !== want.chosen_seq ||
                    out_data.chosen_parts !== want.chosen_parts)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"%0t: result mismatch, expected found=%0d slot=%0d ",
                                  "seq=%h parts=%h, got found=%0d slot=%0d seq=%h parts=%h"},
                                 $time, want.found, want.chosen_slot, want.chosen_seq,
                                 want.chosen_parts, out_data.found, out_data.chosen_slot,
                                 out_data.chosen_seq, out_data.chosen_parts);
                end
            end
        end
    end

    // Result side: for each transaction, wait a random number of cycles after valid shows.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                recv_calm = !recv_calm;
            stall = recv_calm ? 0 : $urandom_range(0, 12);
            if (stall == 0)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                do
                    @(posedge clk);
                while (!out_valid);
                repeat (stall) @(negedge clk);
                out_ready <= 1'b1;
            end
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    // Guard against a hung handshake.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("end of test: mismatches");
        $finish;
    end

    // Stimulus: reset, directed table, then random phases under varied settings.
    initial
    begin
        int        counted;
        in_item_t  it;
        out_item_t none;
        logic [COUNT_W-1:0] phase_count [NUM_PHASES];
        bit                 phase_tie   [NUM_PHASES];

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        none      = '0;
        for (int i = 0; i < SLOTS_DEF; i++)
        begin
            full_flag[i] = 1'b0;
            busy_flag[i] = 1'b0;
            tag_seq[i]   = '0;
            tag_parts[i] = '0;
        end
        cur_count = SLOTS_IN_USE_RST;
        cur_tie   = 1'b1;

        // Slot counts include zero and values past the table size.
        phase_count = '{4'd8, 4'd8, 4'd1, 4'd0, 4'd12, 4'd3, 4'd5, 4'd15, 4'd8};
        phase_tie   = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};

        // Directed rows under reset settings: all slots active, parts tie-break on.
        add_row(KIND_TAKE,    5, '1, '1, 1, 0, 0, '0, '0);
        add_row(KIND_FILL,    0, '1, '1, 0, 0, 0, '0, '0);
        add_row(KIND_FILL,    7, '0, '1, 0, 0, 0, '0, '0);
        add_row(KIND_FILL,    3, '0, '0, 0, 0, 0, '0, '0);
        add_row(KIND_TAKE,    0, '0, '0, 1, 1, 3, '0, '0);
        add_row(KIND_TAKE,    0, '0, '0, 1, 1, 7, '0, '1);
        add_row(KIND_TAKE,    0, '0, '0, 1, 1, 0, '1, '1);
        add_row(KIND_TAKE,    0, '0, '0, 1, 0, 0, '0, '0);
        // Refill of a slot still in use stays in use.
        add_row(KIND_FILL,    3, 32'd5, 32'd9, 0, 0, 0, '0, '0);
        add_row(KIND_TAKE,    0, '0, '0, 1, 0, 0, '0, '0);
        add_row(KIND_RELEASE, 3, '0, '0, 0, 0, 0, '0, '0);
        add_row(KIND_FILL,    3, 32'd5, 32'd9, 0, 0, 0, '0, '0);
        // Full tie on both tags goes to the lower index.
        add_row(KIND_FILL,    5, 32'd5, 32'd9, 0, 0, 0, '0, '0);
        add_row(KIND_TAKE,    6, '1, '1, 1, 1, 3, 32'd5, 32'd9);
        add_row(KIND_UNUSED,  6, 32'h1234_5678, 32'h9abc_def0, 0, 0, 0, '0, '0);
        add_row(KIND_TAKE,    0, '0, '0, 1, 1, 5, 32'd5, 32'd9);
        add_row(KIND_RELEASE, 0, '0, '0, 0, 0, 0, '0, '0);
        add_row(KIND_RELEASE, 7, '0, '0, 0, 0, 0, '0, '0);
        add_row(KIND_FILL,    1, 32'h8000_0000, 32'h5555_5555, 0, 0, 0, '0, '0);
        add_row(KIND_FILL,    2, 32'h7fff_ffff, 32'haaaa_aaaa, 0, 0, 0, '0, '0);
        add_row(KIND_TAKE,    0, '0, '0, 1, 1, 2, 32'h7fff_ffff, 32'haaaa_aaaa);
        add_row(KIND_TAKE,    0, '0, '0, 1, 1, 1, 32'h8000_0000, 32'h5555_5555);
        add_row(KIND_FILL,    4, 32'd6, 32'd2, 0, 0, 0, '0, '0);
        add_row(KIND_FILL,    6, 32'd6, 32'd1, 0, 0, 0, '0, '0);
        add_row(KIND_TAKE,    0, '0, '0, 0, 0, 0, '0, '0);

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_tab[i])
            send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);

        // Random phases; registers change only once the block has gone quiet.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            in_valid <= 1'b0;
            drain_and_settle();
            write_reg(CFG_SLOTS_IN_USE, phase_count[p]);
            write_reg(CFG_PARTS_TIE_BREAK,
                      {CFG_DAT_W'($urandom_range(0, 7)) << 1} | CFG_DAT_W'(phase_tie[p]));
            write_reg((p % 2 == 0) ? CFG_SPARE_A : CFG_SPARE_B,
                      CFG_DAT_W'($urandom_range(0, 15)));
            @(negedge clk);
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                it = random_item();
                send_item(it, 1'b0, none);
                if (it.kind != KIND_UNUSED)
                    counted++;
            end
        end

        in_valid <= 1'b0;
        drain_and_settle();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
